### rtl/smt_pkg.sv
// Shared types and constants of the SMBus master transfer sequencer.
// Used by the top level and smt_core under rtl; it depends on nothing else.
`default_nettype none

package smt_pkg;

  localparam int BUF_DEPTH_DEF = 16;

  // Item kinds carried in the slave-side tuser.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_LOAD   = 2'd1,
    OP_START  = 2'd2
  } op_t;

  // Transfer status reported with every result.
  typedef enum logic [1:0] {
    XS_BUSY       = 2'd0,
    XS_FAILED     = 2'd1,
    XS_READ_DONE  = 2'd2,
    XS_WRITE_DONE = 2'd3
  } xs_t;

  // Bus engine status codes that the sequencer acts on.
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RSTART   = 8'h10;
  localparam logic [7:0] ST_MT_AACK  = 8'h18;
  localparam logic [7:0] ST_MT_DACK  = 8'h28;
  localparam logic [7:0] ST_MR_AACK  = 8'h40;
  localparam logic [7:0] ST_MR_DACK  = 8'h50;
  localparam logic [7:0] ST_MR_DNACK = 8'h58;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ADDR_RW  = 2'd0;
  localparam logic [1:0] REG_REG_ADDR = 2'd1;
  localparam logic [1:0] REG_XFER_LEN = 2'd2;

  localparam logic [7:0] ADDR_RW_RESET = 8'hD0;
  localparam logic [4:0] CNT_MAX       = 5'd31;
  localparam logic [4:0] RD_LEN_MAX    = 5'd16;

  typedef struct packed {
    logic [7:0] addr_rw_byte;
    logic [7:0] reg_addr;
    logic [4:0] xfer_len;
  } cfg_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] load_data;
    logic [3:0] load_index;
    logic [7:0] rx_byte_in;
    logic [7:0] status_code;
  } item_t;

  // First member sits in the highest bits, so tx_byte lands in bits 7:0.
  typedef struct packed {
    xs_t        xfer_status;
    logic       bus_reset;
    logic       ack_enable;
    logic       stop_req;
    logic       start_req;
    logic       rx_valid;
    logic [3:0] rx_index;
    logic [7:0] rx_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } res_t;

endpackage

`default_nettype wire

### rtl/smbus_master_transfer_sequencer_top.sv
// Top level of the SMBus master transfer sequencer: stream ports, register port,
// input and result registers. Depends on smt_pkg, smt_wbuf and smt_core.
`default_nettype none

// Every accepted item gives exactly one result. The block takes one item per
// clock cycle while the input side is not stalled. An accepted item is held in
// the input register and is then taken into the result register, whose output is
// the master side; that move waits while a result is held there. The input side
// stalls only while a result waits with m_axis_tready low and the input register
// is also full. Load items write the write buffer; the buffer read for the next
// data byte is done ahead, at the count left by the previous item.
// Registers: addr_rw_byte at 0x0, reg_addr at 0x4, xfer_len at 0x8.
module smbus_master_transfer_sequencer_top #(
  parameter int BUF_DEPTH = smt_pkg::BUF_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // status_code [7:0], rx_byte_in [15:8], load_index [19:16], load_data [27:20]
  input  wire logic [31:0] s_axis_tdata,
  // opcode [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tx_byte [7:0], tx_valid [8], rx_data [16:9], rx_index [20:17], rx_valid [21],
  // start_req [22], stop_req [23], ack_enable [24], bus_reset [25],
  // xfer_status [27:26]
  output logic      [31:0] m_axis_tdata,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import smt_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  res_t    out_res;
  res_t    res;
  logic    adv;
  logic    in_acc;
  logic    cfg_wr;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.addr_rw_byte <= ADDR_RW_RESET;
      cfg.reg_addr     <= 8'd0;
      cfg.xfer_len     <= 5'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ADDR_RW:  cfg.addr_rw_byte <= pwdata[7:0];
        REG_REG_ADDR: cfg.reg_addr     <= pwdata[7:0];
        REG_XFER_LEN: cfg.xfer_len     <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ADDR_RW:  prdata = {24'd0, cfg.addr_rw_byte};
      REG_REG_ADDR: prdata = {24'd0, cfg.reg_addr};
      REG_XFER_LEN: prdata = {27'd0, cfg.xfer_len};
      default:      prdata = 32'd0;
    endcase
  end

  // Input register; it advances whenever the result register is free or drains.
  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_acc || (in_valid && !adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item.opcode      <= op_t'(s_axis_tuser);
      in_item.status_code <= s_axis_tdata[7:0];
      in_item.rx_byte_in  <= s_axis_tdata[15:8];
      in_item.load_index  <= s_axis_tdata[19:16];
      in_item.load_data   <= s_axis_tdata[27:20];
    end
  end

  smt_wbuf #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_wbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  smt_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .item    (in_item),
    .cfg     (cfg),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {4'd0, out_res};

  // The input side stalls only when both registers are full and the output is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  // A result never both sends and receives a byte.
  a_tx_rx_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_res.tx_valid && out_res.rx_valid))
    else $error("result carries both tx and rx bytes");

  // A bus reset always reports a failed transfer.
  a_reset_fail: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_res.bus_reset) |-> (out_res.xfer_status == XS_FAILED))
    else $error("bus reset without failed status");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

### rtl/smt_wbuf.sv
// Write data buffer of the sequencer: one write port, one registered read port.
// Depends on nothing but its parameter.
`default_nettype none

module smt_wbuf #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [((BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [7:0]                                  wr_data,
  input  wire logic [((BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1)-1:0] rd_addr,
  output logic      [7:0]                                  rd_data
);

  logic [7:0] mem [BUF_DEPTH];

  // A write to the entry being read is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/smt_core.sv
// Transfer state and the single-pass decode of one item into one result.
// Depends on smt_pkg; the write buffer it addresses lives in smt_wbuf.
`default_nettype none

module smt_core #(
  parameter int BUF_DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        adv,
  input  wire smt_pkg::item_t                              item,
  input  wire smt_pkg::cfg_t                               cfg,
  input  wire logic [7:0]                                  rd_data,
  output logic      [((BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1)-1:0] rd_addr,
  output logic                                             wr_en,
  output logic      [((BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1)-1:0] wr_addr,
  output logic      [7:0]                                  wr_data,
  output smt_pkg::res_t                                    res
);

  import smt_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic [4:0] byte_count, byte_count_next;
  logic       start_bit, start_bit_next;
  logic       stop_bit, stop_bit_next;
  logic       ack_bit, ack_bit_next;
  xs_t        done_status, done_status_next;

  logic [4:0]    wr_len;
  logic [4:0]    rd_len;
  logic [4:0]    count_inc;
  logic [AW+4:0] bc_ext;
  logic [AW+3:0] li_ext;

  always_comb begin
    wr_len = (32'(cfg.xfer_len) > BUF_DEPTH) ? 5'(BUF_DEPTH) : cfg.xfer_len;
    if (cfg.xfer_len == 5'd0) begin
      rd_len = 5'd1;
    end else if (cfg.xfer_len > RD_LEN_MAX) begin
      rd_len = RD_LEN_MAX;
    end else begin
      rd_len = cfg.xfer_len;
    end
    count_inc = (byte_count == CNT_MAX) ? byte_count : byte_count + 5'd1;
  end

  always_comb begin
    res              = '0;
    byte_count_next  = byte_count;
    start_bit_next   = start_bit;
    stop_bit_next    = stop_bit;
    ack_bit_next     = ack_bit;
    done_status_next = done_status;
    unique case (item.opcode)
      OP_LOAD: begin
        // The buffer write itself is driven below.
      end
      OP_START: begin
        start_bit_next   = 1'b1;
        stop_bit_next    = 1'b0;
        done_status_next = XS_BUSY;
      end
      OP_STATUS: begin
        unique case (item.status_code) inside
          ST_START, ST_RSTART: begin
            res.tx_byte     = cfg.addr_rw_byte;
            res.tx_valid    = 1'b1;
            start_bit_next  = 1'b0;
            byte_count_next = 5'd0;
          end
          ST_MT_AACK: begin
            res.tx_byte  = cfg.reg_addr;
            res.tx_valid = 1'b1;
          end
          ST_MT_DACK: begin
            if (byte_count < wr_len) begin
              res.tx_byte     = rd_data;
              res.tx_valid    = 1'b1;
              byte_count_next = count_inc;
            end else begin
              done_status_next = XS_WRITE_DONE;
              stop_bit_next    = 1'b1;
            end
          end
          ST_MR_AACK: begin
            ack_bit_next = (rd_len != 5'd1);
          end
          ST_MR_DACK: begin
            if (byte_count < rd_len) begin
              res.rx_data     = item.rx_byte_in;
              res.rx_index    = byte_count[3:0];
              res.rx_valid    = 1'b1;
              byte_count_next = count_inc;
            end
            // Drop the acknowledge once the next byte will be the last one.
            ack_bit_next = !(({1'b0, byte_count_next} + 6'd1) >= {1'b0, rd_len});
          end
          ST_MR_DNACK: begin
            res.rx_data      = item.rx_byte_in;
            res.rx_index     = byte_count[3:0];
            res.rx_valid     = 1'b1;
            byte_count_next  = count_inc;
            stop_bit_next    = 1'b1;
            ack_bit_next     = 1'b1;
            done_status_next = XS_READ_DONE;
          end
          default: begin
            res.bus_reset    = 1'b1;
            start_bit_next   = 1'b0;
            stop_bit_next    = 1'b0;
            ack_bit_next     = 1'b0;
            done_status_next = XS_FAILED;
          end
        endcase
      end
      default: begin
      end
    endcase
    res.start_req   = start_bit_next;
    res.stop_req    = stop_bit_next;
    res.ack_enable  = ack_bit_next;
    res.xfer_status = done_status_next;
  end

  // Buffer ports. The read address follows the count after this item, so the
  // read register holds the entry at byte_count when the next item arrives.
  always_comb begin
    li_ext  = {{AW{1'b0}}, item.load_index};
    wr_en   = adv && (item.opcode == OP_LOAD) && (32'(item.load_index) < BUF_DEPTH);
    wr_addr = li_ext[AW-1:0];
    wr_data = item.load_data;
    bc_ext  = adv ? {{AW{1'b0}}, byte_count_next} : {{AW{1'b0}}, byte_count};
    rd_addr = bc_ext[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 5'd0;
      start_bit   <= 1'b0;
      stop_bit    <= 1'b0;
      ack_bit     <= 1'b1;
      done_status <= XS_BUSY;
    end else if (adv) begin
      byte_count  <= byte_count_next;
      start_bit   <= start_bit_next;
      stop_bit    <= stop_bit_next;
      ack_bit     <= ack_bit_next;
      done_status <= done_status_next;
    end
  end

endmodule

`default_nettype wire

### test/smt_result_checker.sv
// Result checker for the SMBus master transfer sequencer: watches both stream channels
// and the register port, predicts every result and compares it field by field.
// Depends on smt_pkg for the item, result and configuration types and the status codes.
module smt_result_checker #(
  parameter int BUF_DEPTH = smt_pkg::BUF_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               error_count,
  output int               results_checked,
  output int               pending
);

  import smt_pkg::*;

  localparam int REPORT_LIMIT = 200;

  // Shadow of the sequencer's registers and state.
  cfg_t       cfg;
  logic [7:0] tx_buf [BUF_DEPTH];
  logic [4:0] byte_cnt;
  logic       start_q;
  logic       stop_q;
  logic       ack_q;
  xs_t        xstat;

  res_t expected_results [$];

  task automatic flag_error(input string what);
    if (error_count < REPORT_LIMIT)
      $display("%0t: %s", $time, what);
    else if (error_count == REPORT_LIMIT)
      $display("%0t: further mismatches are not shown", $time);
    error_count++;
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      flag_error($sformatf("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got));
  endtask

  function automatic void bump_count();
    if (byte_cnt != CNT_MAX) byte_cnt++;
  endfunction

  // Applies one item to the shadow state and returns the result it must produce.
  function automatic res_t sequence_event(input item_t it);
    res_t r;
    int   wr_len;
    int   rd_len;
    r = '0;
    wr_len = (int'(cfg.xfer_len) > BUF_DEPTH) ? BUF_DEPTH : int'(cfg.xfer_len);
    rd_len = (cfg.xfer_len == 0) ? 1 :
             ((cfg.xfer_len > RD_LEN_MAX) ? int'(RD_LEN_MAX) : int'(cfg.xfer_len));
    case (it.opcode)
      OP_LOAD: begin
        if (int'(it.load_index) < BUF_DEPTH) tx_buf[it.load_index] = it.load_data;
      end
      OP_START: begin
        start_q = 1'b1;
        stop_q  = 1'b0;
        xstat   = XS_BUSY;
      end
      OP_STATUS: begin
        case (it.status_code)
          ST_START, ST_RSTART: begin
            r.tx_byte  = cfg.addr_rw_byte;
            r.tx_valid = 1'b1;
            start_q    = 1'b0;
            byte_cnt   = '0;
          end
          ST_MT_AACK: begin
            r.tx_byte  = cfg.reg_addr;
            r.tx_valid = 1'b1;
          end
          ST_MT_DACK: begin
            if (int'(byte_cnt) < wr_len && int'(byte_cnt) < BUF_DEPTH) begin
              r.tx_byte  = tx_buf[byte_cnt];
              r.tx_valid = 1'b1;
              bump_count();
            end else begin
              xstat  = XS_WRITE_DONE;
              stop_q = 1'b1;
            end
          end
          ST_MR_AACK: begin
            ack_q = (rd_len == 1) ? 1'b0 : 1'b1;
          end
          ST_MR_DACK: begin
            // Bytes past the read length are dropped; only the acknowledge moves.
            if (int'(byte_cnt) < rd_len) begin
              r.rx_data  = it.rx_byte_in;
              r.rx_index = byte_cnt[3:0];
              r.rx_valid = 1'b1;
              bump_count();
            end
            ack_q = (int'(byte_cnt) + 1 >= rd_len) ? 1'b0 : 1'b1;
          end
          ST_MR_DNACK: begin
            r.rx_data  = it.rx_byte_in;
            r.rx_index = byte_cnt[3:0];
            r.rx_valid = 1'b1;
            bump_count();
            stop_q = 1'b1;
            ack_q  = 1'b1;
            xstat  = XS_READ_DONE;
          end
          default: begin
            r.bus_reset = 1'b1;
            start_q     = 1'b0;
            stop_q      = 1'b0;
            ack_q       = 1'b0;
            xstat       = XS_FAILED;
          end
        endcase
      end
      default: ;
    endcase
    r.start_req   = start_q;
    r.stop_req    = stop_q;
    r.ack_enable  = ack_q;
    r.xfer_status = xstat;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    item_t it;
    res_t  got;
    res_t  want;
    if (rst) begin
      cfg.addr_rw_byte = ADDR_RW_RESET;
      cfg.reg_addr     = '0;
      cfg.xfer_len     = '0;
      for (int i = 0; i < BUF_DEPTH; i++) tx_buf[i] = '0;
      byte_cnt = '0;
      start_q  = 1'b0;
      stop_q   = 1'b0;
      ack_q    = 1'b1;
      xstat    = XS_BUSY;
      expected_results.delete();
      error_count     = 0;
      results_checked = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ADDR_RW:  cfg.addr_rw_byte = pwdata[7:0];
          REG_REG_ADDR: cfg.reg_addr     = pwdata[7:0];
          REG_XFER_LEN: cfg.xfer_len     = pwdata[4:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[27:0]);
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: expected none, actual 0x%0h",
                               m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
          check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
          check_field("rx_data", 32'(want.rx_data), 32'(got.rx_data));
          check_field("rx_index", 32'(want.rx_index), 32'(got.rx_index));
          check_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
          check_field("start_req", 32'(want.start_req), 32'(got.start_req));
          check_field("stop_req", 32'(want.stop_req), 32'(got.stop_req));
          check_field("ack_enable", 32'(want.ack_enable), 32'(got.ack_enable));
          check_field("bus_reset", 32'(want.bus_reset), 32'(got.bus_reset));
          check_field("xfer_status", 32'(want.xfer_status), 32'(got.xfer_status));
          check_field("tdata padding", 0, 32'(m_axis_tdata[31:28]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.opcode      = op_t'(s_axis_tuser);
        it.status_code = s_axis_tdata[7:0];
        it.rx_byte_in  = s_axis_tdata[15:8];
        it.load_index  = s_axis_tdata[19:16];
        it.load_data   = s_axis_tdata[27:20];
        expected_results.push_back(sequence_event(it));
      end
      pending <= expected_results.size();
    end
  end

endmodule

### test/tb_smbus_master_transfer_sequencer_top.sv
// Testbench top for the SMBus master transfer sequencer: clock, reset, item and register
// stimulus, receiver stalls and the verdict. Depends on smt_pkg, the RTL and smt_result_checker.
module tb_smbus_master_transfer_sequencer_top;
  import smt_pkg::*;

  localparam int CYCLE        = 12;
  localparam int DEPTH        = BUF_DEPTH_DEF;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int LONG_HOLD    = 120;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int TIMEOUT_CYCLES = 500000;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Bus engine codes that the sequencer treats as failures.
  localparam logic [7:0] ST_BUS_ERR   = 8'h00;
  localparam logic [7:0] ST_MT_ANACK  = 8'h20;
  localparam logic [7:0] ST_MT_DNACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;
  localparam logic [7:0] ST_MR_ANACK  = 8'h48;
  localparam logic [7:0] ST_NO_INFO   = 8'hF8;
  localparam logic [7:0] ST_UNDEFINED = 8'hFF;

  typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int error_count;
  int results_checked;
  int pending;

  // Sender bookkeeping.
  int              items_sent = 0;
  int              burst_left = 0;
  bit              back_to_back = 1'b0;
  logic [4:0]      cfg_len = '0;
  logic [DEPTH-1:0] loaded = '0;

  // Receiver bookkeeping.
  int       hold_requests = 0;
  int       holds_served = 0;
  int       hold_left = 0;
  int       seg_left = 0;
  rx_mode_t seg_mode = RX_FREE;

  smbus_master_transfer_sequencer_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  smt_result_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .error_count(error_count), .results_checked(results_checked), .pending(pending)
  );

  always begin
    #(CYCLE / 2) clk = 1'b1;
    #(CYCLE / 2) clk = 1'b0;
  end

  initial begin
    #(CYCLE * TIMEOUT_CYCLES);
    $display("%0t: timeout with %0d results outstanding", $time, pending);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: a long hold-off when asked, otherwise stretches of different stall patterns.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served = holds_served + 1;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(1, 40);
      end
      seg_left = seg_left - 1;
      case (seg_mode)
        RX_FREE:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default:   m_axis_tready <= (seg_left % 3 == 0);
      endcase
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] st, input logic [7:0] rxb,
                           input logic [3:0] li, input logic [7:0] ld);
    int gap;
    if (burst_left == 0 && !back_to_back) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        7: gap = $urandom_range(10, 40);
        default: gap = $urandom_range(1, 4);
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, ld, li, rxb, st};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left != 0) burst_left--;
    if (op != OP_RESERVED) items_sent++;
  endtask

  task automatic send_status(input logic [7:0] st, input logic [7:0] rxb);
    send_item(OP_STATUS, st, rxb, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_load(input logic [3:0] li, input logic [7:0] ld);
    send_item(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), li, ld);
    loaded[li] = 1'b1;
  endtask

  task automatic send_start();
    send_item(OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  // Lowers valid and waits until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // A data-ACK in a write may only go out once every entry it could send was loaded.
  function automatic bit tx_entries_loaded();
    int n;
    n = (int'(cfg_len) > DEPTH) ? DEPTH : int'(cfg_len);
    for (int i = 0; i < n; i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] fail_status();
    case ($urandom_range(0, 6))
      0: return ST_BUS_ERR;
      1: return ST_MT_ANACK;
      2: return ST_MT_DNACK;
      3: return ST_ARB_LOST;
      4: return ST_MR_ANACK;
      5: return ST_NO_INFO;
      default: return ST_UNDEFINED;
    endcase
  endfunction

  function automatic logic [7:0] any_status();
    case ($urandom_range(0, 9))
      0: return ST_START;
      1: return ST_RSTART;
      2: return ST_MT_AACK;
      3: return ST_MT_DACK;
      4: return ST_MR_AACK;
      5: return ST_MR_DACK;
      6: return ST_MR_DNACK;
      7: return fail_status();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic noise_item();
    logic [7:0] st;
    case ($urandom_range(0, 3))
      0: send_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      1: send_start();
      2: begin
        st = any_status();
        if (st == ST_MT_DACK && !tx_entries_loaded()) st = ST_MR_AACK;
        send_status(st, 8'($urandom_range(0, 255)));
      end
      default: send_item(OP_RESERVED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic write_transfer();
    int wl;
    int abort_at;
    wl = (int'(cfg_len) > DEPTH) ? DEPTH : int'(cfg_len);
    abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, wl + 1) : -1;
    for (int i = 0; i < wl; i++)
      if (!loaded[i] || $urandom_range(0, 1)) send_load(4'(i), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) != 0) send_start();
    send_status(($urandom_range(0, 3) == 0) ? ST_RSTART : ST_START,
                8'($urandom_range(0, 255)));
    for (int k = 0; k <= wl + 1; k++) begin
      if (k == abort_at) begin
        send_status(fail_status(), 8'($urandom_range(0, 255)));
        return;
      end
      send_status((k == 0) ? ST_MT_AACK : ST_MT_DACK, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) send_status(ST_MT_DACK, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_transfer();
    int rl;
    int abort_at;
    rl = (cfg_len == 0) ? 1 : ((cfg_len > RD_LEN_MAX) ? int'(RD_LEN_MAX) : int'(cfg_len));
    abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, rl) : -1;
    if ($urandom_range(0, 7) != 0) send_start();
    send_status(($urandom_range(0, 3) == 0) ? ST_RSTART : ST_START,
                8'($urandom_range(0, 255)));
    for (int k = 0; k <= rl; k++) begin
      if (k == abort_at) begin
        send_status(fail_status(), 8'($urandom_range(0, 255)));
        return;
      end
      // Now and then the bus engine hands in one byte more than asked for.
      if (k == rl && $urandom_range(0, 3) == 0)
        send_status(ST_MR_DACK, 8'($urandom_range(0, 255)));
      send_status((k == 0) ? ST_MR_AACK : ((k == rl) ? ST_MR_DNACK : ST_MR_DACK),
                  8'($urandom_range(0, 255)));
    end
  endtask

  // Enough NACKed reads in a row to drive the byte count into saturation.
  task automatic saturating_read();
    send_start();
    send_status(ST_START, 8'($urandom_range(0, 255)));
    repeat (34) send_status(ST_MR_DNACK, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 16) write_transfer();
    else if (pick < 32) read_transfer();
    else if (pick < 39) repeat ($urandom_range(1, 6)) noise_item();
    else saturating_read();
  endtask

  initial begin : stimulus
    logic [7:0] addr_byte;
    logic [7:0] reg_byte;
    logic [4:0] len;
    int goal;
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: every opcode, every status kind, field extremes.
    send_item(OP_RESERVED, 8'h00, 8'h00, 4'h0, 8'h00);
    send_status(ST_MT_DACK, 8'h00);
    send_load(4'd0, 8'h00);
    send_load(4'd15, 8'hFF);
    send_start();
    send_status(ST_START, 8'h00);
    send_status(ST_MT_AACK, 8'hFF);
    send_status(ST_MT_DACK, 8'h00);
    send_start();
    send_status(ST_RSTART, 8'h00);
    send_status(ST_MR_AACK, 8'h00);
    send_status(ST_MR_DACK, 8'hFF);
    send_status(ST_MR_DACK, 8'h00);
    send_status(ST_MR_DNACK, 8'hA5);
    send_status(ST_BUS_ERR, 8'hFF);
    send_status(ST_UNDEFINED, 8'h00);
    send_status(ST_ARB_LOST, 8'h5A);
    send_status(ST_MT_ANACK, 8'hFF);
    send_item(OP_RESERVED, 8'hFF, 8'hFF, 4'hF, 8'hFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin addr_byte = 8'h00; reg_byte = 8'hFF; len = 5'd1; end
        1: begin addr_byte = 8'hFF; reg_byte = 8'h00; len = 5'd16; end
        2: begin addr_byte = 8'($urandom_range(0, 255)); reg_byte = 8'($urandom_range(0, 255));
                 len = 5'd0; end
        default: begin
          addr_byte = 8'($urandom_range(0, 255));
          reg_byte  = 8'($urandom_range(0, 255));
          len       = 5'($urandom_range(0, 16));
        end
      endcase
      reg_write(REG_ADDR_RW, {24'h0, addr_byte});
      reg_write(REG_REG_ADDR, {24'h0, reg_byte});
      reg_write(REG_XFER_LEN, {27'h0, len});
      cfg_len = len;
      goal = items_sent + PHASE_ITEMS;
      if (ph == 3) begin
        // Receiver holds off while items keep coming, so the input side must stall.
        hold_requests <= hold_requests + 1;
        back_to_back = 1'b1;
        read_transfer();
        write_transfer();
        read_transfer();
        back_to_back = 1'b0;
      end
      while (items_sent < goal) random_sequence();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d items over %0d register settings: writes, reads, aborts, noise.",
             items_sent, PHASES + 1);
    $display("Compared %0d results, %0d mismatches.", results_checked, error_count);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
